[design/mmc_pkg.sv]
// Shared types and constants of the minimum mean cycle solver.
`timescale 1ns / 1ps
`default_nettype none
package mmc_pkg;

  localparam int unsigned MAX_NODES_DEF   = 64;
  localparam int unsigned MAX_EDGES_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned ID_W      = 7;
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned NUM_W     = 23;
  localparam int unsigned DEN_OUT_W = 7;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_CLR, S_E_RD, S_E_SRC, S_E_DST, S_E_UPD,
    S_F_TOP, S_F_TOPW, S_F_RD, S_F_TERM, S_F_BEST,
    S_G_LOAD, S_G_DIV, S_G_WAIT, S_Q_NUM, S_Q_NUMW, S_Q_DEN, S_Q_DENW, S_OUT
  } state_e;

  // distance table address select
  typedef enum logic [2:0] {
    DA_KV, DA_K1V, DA_KU, DA_K1T, DA_N1V
  } dsel_e;

  // distance table write mode
  typedef enum logic [1:0] {
    DW_NONE, DW_ZERO, DW_INV, DW_RELAX
  } dwe_e;

  // divider operand select
  typedef enum logic [1:0] {
    DS_GCD, DS_NUM, DS_DEN
  } dsrc_e;

  typedef struct packed {
    logic  load;
    dsel_e dsel;
    dwe_e  dwe;
    logic  v_rst;
    logic  v_inc;
    logic  k_rst;
    logic  k_inc;
    logic  i_rst;
    logic  i_inc;
    logic  total_clr;
    logic  e_latch;
    logic  c_latch;
    logic  t_latch;
    logic  top_rst;
    logic  top_upd;
    logic  best_rst;
    logic  best_upd;
    logic  g_load;
    logic  g_step;
    logic  div_start;
    dsrc_e dsrc;
    logic  num_latch;
    logic  den_latch;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic d_ok;
    logic v_last;
    logic k_last;
    logic i_end;
    logic n_zero;
    logic found;
    logic div_done;
    logic rem_zero;
  } sts_t;

endpackage
`default_nettype wire

[design/minimum_mean_cycle_solver_core.sv]
// Top level of the minimum mean cycle solver (Karp).
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+----------------------------------------
//  command  | start / busy, transfer: start&!busy | opcode_i, edge_from_i, edge_to_i,
//           |                                  |   edge_weight_i
//  config   | cfg_valid_i / cfg_ready_o        | cfg_data_i (node_count)
//  result   | result_valid_o, one-cycle strobe | has_cycle_o, mean_numerator_o,
//           |                                  |   mean_denominator_o
//
// An edge load leaves busy low, so loads stream one per cycle.
// A solve relaxes the single-port walk table level by level, then reduces the
// fraction with a gcd (Euclid steps) and two divisions on a bit-serial divider.
// busy is high for the whole solve; the result strobe ends it.
// Reset clears node_count to one and empties the edge store; the walk table needs
// no clearing pass since each solve rewrites every entry it reads.
// The receiver cannot stall: result_valid_o is high for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module minimum_mean_cycle_solver_core #(
  parameter int unsigned MAX_NODES   = mmc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = mmc_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = mmc_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode_i,
  input  wire logic [mmc_pkg::ID_W-1:0]      edge_from_i,
  input  wire logic [mmc_pkg::ID_W-1:0]      edge_to_i,
  input  wire logic [mmc_pkg::WIN_W-1:0]     edge_weight_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mmc_pkg::ID_W-1:0]      cfg_data_i,
  output logic                               result_valid_o,
  output logic                               has_cycle_o,
  output logic [mmc_pkg::NUM_W-1:0]          mean_numerator_o,
  output logic [mmc_pkg::DEN_OUT_W-1:0]      mean_denominator_o
);
  import mmc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // User lands config writes only while idle; unenforced, the register takes them all.
  assign cfg_ready_o = 1'b1;

  // Sequence loads, level-by-level relaxation, mean search and reduction.
  mmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .res_valid_o (result_valid_o)
  );

  // Hold the edge store, the walk table d[k][v] and the fraction arithmetic.
  mmc_dp #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .edge_from_i        (edge_from_i),
    .edge_to_i          (edge_to_i),
    .edge_weight_i      (edge_weight_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .has_cycle_o        (has_cycle_o),
    .mean_numerator_o   (mean_numerator_o),
    .mean_denominator_o (mean_denominator_o)
  );
endmodule
`default_nettype wire

[design/mmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[design/mmc_ctrl.sv]
// Controller state machine of the minimum mean cycle solver.
`timescale 1ns / 1ps
`default_nettype none
module mmc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          opcode_i,
  input  wire mmc_pkg::sts_t sts_i,
  output mmc_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               res_valid_o
);
  import mmc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && opcode_i) state_d = sts_i.n_zero ? S_OUT : S_INIT;
      end
      S_INIT:   state_d = sts_i.v_last ? S_CLR : S_INIT;
      S_CLR:    state_d = sts_i.v_last ? S_E_RD : S_CLR;
      S_E_RD: begin
        if (!sts_i.i_end) state_d = S_E_SRC;
        else if (sts_i.k_last) state_d = S_F_TOP;
        else state_d = S_CLR;
      end
      S_E_SRC:  state_d = sts_i.edge_ok ? S_E_DST : S_E_RD;
      S_E_DST:  state_d = S_E_UPD;
      S_E_UPD:  state_d = S_E_RD;
      S_F_TOP:  state_d = S_F_TOPW;
      S_F_TOPW: begin
        if (sts_i.d_ok) state_d = S_F_RD;
        else if (sts_i.v_last) state_d = S_G_LOAD;
        else state_d = S_F_TOP;
      end
      S_F_RD:   state_d = S_F_TERM;
      S_F_TERM: state_d = sts_i.k_last ? S_F_BEST : S_F_RD;
      S_F_BEST: state_d = sts_i.v_last ? S_G_LOAD : S_F_TOP;
      S_G_LOAD: state_d = sts_i.found ? S_G_DIV : S_OUT;
      S_G_DIV:  state_d = S_G_WAIT;
      S_G_WAIT: begin
        if (sts_i.div_done) state_d = sts_i.rem_zero ? S_Q_NUM : S_G_DIV;
      end
      S_Q_NUM:  state_d = S_Q_NUMW;
      S_Q_NUMW: if (sts_i.div_done) state_d = S_Q_DEN;
      S_Q_DEN:  state_d = S_Q_DENW;
      S_Q_DENW: if (sts_i.div_done) state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy_o      = (state_q != S_IDLE);
    res_valid_o = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !opcode_i) cmd_o.load = 1'b1;
        if (start_i && opcode_i) begin
          cmd_o.best_rst = 1'b1;
          cmd_o.v_rst    = 1'b1;
          cmd_o.k_rst    = 1'b1;
        end
      end
      S_INIT: begin
        cmd_o.dsel = DA_KV;
        cmd_o.dwe  = DW_ZERO;
        if (sts_i.v_last) cmd_o.v_rst = 1'b1;
        else cmd_o.v_inc = 1'b1;
      end
      S_CLR: begin
        cmd_o.dsel = DA_K1V;
        cmd_o.dwe  = DW_INV;
        if (sts_i.v_last) begin
          cmd_o.v_rst = 1'b1;
          cmd_o.i_rst = 1'b1;
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      S_E_RD: begin
        if (sts_i.i_end && !sts_i.k_last) cmd_o.k_inc = 1'b1;
      end
      S_E_SRC: begin
        cmd_o.e_latch = 1'b1;
        cmd_o.dsel    = DA_KU;
        if (!sts_i.edge_ok) cmd_o.i_inc = 1'b1;
      end
      S_E_DST: begin
        cmd_o.c_latch = 1'b1;
        cmd_o.dsel    = DA_K1T;
      end
      S_E_UPD: begin
        cmd_o.dsel  = DA_K1T;
        cmd_o.dwe   = DW_RELAX;
        cmd_o.i_inc = 1'b1;
      end
      S_F_TOP: cmd_o.dsel = DA_N1V;
      S_F_TOPW: begin
        cmd_o.t_latch = 1'b1;
        cmd_o.top_rst = 1'b1;
        cmd_o.k_rst   = 1'b1;
        if (!sts_i.d_ok && !sts_i.v_last) cmd_o.v_inc = 1'b1;
      end
      S_F_RD: cmd_o.dsel = DA_KV;
      S_F_TERM: begin
        cmd_o.top_upd = 1'b1;
        if (!sts_i.k_last) cmd_o.k_inc = 1'b1;
      end
      S_F_BEST: begin
        cmd_o.best_upd = 1'b1;
        if (!sts_i.v_last) cmd_o.v_inc = 1'b1;
      end
      S_G_LOAD: if (sts_i.found) cmd_o.g_load = 1'b1;
      S_G_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.dsrc      = DS_GCD;
      end
      S_G_WAIT: if (sts_i.div_done) cmd_o.g_step = 1'b1;
      S_Q_NUM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.dsrc      = DS_NUM;
      end
      S_Q_NUMW: if (sts_i.div_done) cmd_o.num_latch = 1'b1;
      S_Q_DEN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.dsrc      = DS_DEN;
      end
      S_Q_DENW: if (sts_i.div_done) cmd_o.den_latch = 1'b1;
      S_OUT: cmd_o.total_clr = 1'b1;
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

[design/mmc_dp.sv]
// Datapath of the minimum mean cycle solver: edge store, walk table, arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module mmc_dp #(
  parameter int unsigned MAX_NODES   = mmc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = mmc_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = mmc_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [mmc_pkg::ID_W-1:0]       cfg_data_i,
  input  wire logic [mmc_pkg::ID_W-1:0]       edge_from_i,
  input  wire logic [mmc_pkg::ID_W-1:0]       edge_to_i,
  input  wire logic [mmc_pkg::WIN_W-1:0]      edge_weight_i,
  input  wire mmc_pkg::cmd_t                  cmd_i,
  output mmc_pkg::sts_t                       sts_o,
  output logic                                has_cycle_o,
  output logic [mmc_pkg::NUM_W-1:0]           mean_numerator_o,
  output logic [mmc_pkg::DEN_OUT_W-1:0]       mean_denominator_o
);
  import mmc_pkg::*;

  localparam int unsigned VW      = $clog2(MAX_NODES + 1);
  localparam int unsigned KW      = $clog2(MAX_NODES + 2);
  localparam int unsigned ROW     = MAX_NODES + 1;
  localparam int unsigned DDEPTH  = (MAX_NODES + 2) * ROW;
  localparam int unsigned DA_W    = $clog2(DDEPTH);
  localparam int unsigned DIST_W  = WEIGHT_BITS + VW;
  localparam int unsigned DEN_W   = VW;
  localparam int unsigned PW      = DIST_W + DEN_W;
  localparam int unsigned ET_W    = $clog2(MAX_EDGES + 1);
  localparam int unsigned EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW      = 2 * ID_W + WEIGHT_BITS;
  localparam int unsigned CW      = $clog2(DIST_W + 1);

  // configuration and node count
  logic [ID_W-1:0] cfg_q;
  logic [VW-1:0]   n_w;

  // counters
  logic [VW-1:0]   v_q;
  logic [KW-1:0]   k_q;
  logic [ET_W-1:0] i_q, total_q;

  // edge store
  logic            e_we, load_ok;
  logic [EW-1:0]   e_wdata, e_rdata;
  logic [ID_W-1:0] r_from, r_to;
  logic [WEIGHT_BITS-1:0] r_w;

  // walk table
  logic [KW-1:0]     row;
  logic [VW-1:0]     col;
  logic [DA_W-1:0]   d_addr;
  logic              d_we;
  logic [DIST_W:0]   d_wdata, d_rdata;
  logic              d_ok;
  logic [DIST_W-1:0] d_val;

  // relaxation and mean search
  logic [VW-1:0]          to_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                   src_ok_q;
  logic [DIST_W-1:0]      cand_q, dn1_q;
  logic [DIST_W-1:0]      top_num_q, best_num_q, tnum;
  logic [DEN_W-1:0]       top_den_q, best_den_q, tden;
  logic [KW:0]            tden_w;
  logic                   found_q, term_ok, term_gt, best_lt;

  // gcd and divider
  logic [DIST_W-1:0] ga_q, div_dvd_q, dvd_sel;
  logic [DEN_W-1:0]  gb_q, div_rem_q, div_dsr_q, dsr_sel;
  logic [CW-1:0]     div_cnt_q;
  logic              div_busy_q, div_ge;
  logic [DEN_W:0]    rem_sh, rem_nx;
  logic [DIST_W-1:0] qnum_q;
  logic [DEN_W-1:0]  qden_q;

  always_comb begin
    n_w = (int'(cfg_q) > int'(MAX_NODES)) ? VW'(MAX_NODES) : VW'(cfg_q);
  end

  // edge load filter
  assign load_ok = (total_q < ET_W'(MAX_EDGES)) &&
                   (edge_from_i != '0) && (int'(edge_from_i) <= int'(n_w)) &&
                   (edge_to_i != '0) && (int'(edge_to_i) <= int'(n_w));
  assign e_we    = cmd_i.load && load_ok;
  assign e_wdata = {edge_from_i, edge_to_i, WEIGHT_BITS'(edge_weight_i)};

  mmc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (EA_W'(total_q)),
    .wdata_i (e_wdata),
    .raddr_i (EA_W'(i_q)),
    .rdata_o (e_rdata)
  );

  assign r_from = e_rdata[EW-1 -: ID_W];
  assign r_to   = e_rdata[WEIGHT_BITS +: ID_W];
  assign r_w    = e_rdata[WEIGHT_BITS-1:0];

  always_comb begin
    row = k_q;
    col = v_q;
    unique case (cmd_i.dsel)
      DA_KV:   begin row = k_q;                    col = v_q;          end
      DA_K1V:  begin row = k_q + KW'(1);           col = v_q;          end
      DA_KU:   begin row = k_q;                    col = VW'(r_from);  end
      DA_K1T:  begin row = k_q + KW'(1);           col = to_q;         end
      DA_N1V:  begin row = KW'(n_w) + KW'(1);      col = v_q;          end
      default: begin row = k_q;                    col = v_q;          end
    endcase
    d_addr = DA_W'(row) * DA_W'(ROW) + DA_W'(col);
  end

  assign d_ok  = d_rdata[DIST_W];
  assign d_val = d_rdata[DIST_W-1:0];

  always_comb begin
    d_we    = 1'b0;
    d_wdata = {1'b1, cand_q};
    unique case (cmd_i.dwe)
      DW_NONE:  d_we = 1'b0;
      DW_ZERO:  begin d_we = 1'b1; d_wdata = {1'b1, {DIST_W{1'b0}}}; end
      DW_INV:   begin d_we = 1'b1; d_wdata = '0; end
      DW_RELAX: d_we = src_ok_q && (!d_ok || (cand_q < d_val));
      default:  d_we = 1'b0;
    endcase
  end

  mmc_ram #(.WIDTH(DIST_W + 1), .DEPTH(DDEPTH)) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_addr),
    .wdata_i (d_wdata),
    .raddr_i (d_addr),
    .rdata_o (d_rdata)
  );

  // one term (d[n+1][v]-d[k][v])/(n+1-k) against the running maximum, and that maximum against the best (smallest) mean
  always_comb begin
    tden_w  = (KW + 1)'(n_w) + (KW + 1)'(1) - (KW + 1)'(k_q);
    tden    = DEN_W'(tden_w);
    tnum    = dn1_q - d_val;
    term_ok = d_ok && (dn1_q >= d_val);
    term_gt = (PW'(tnum) * PW'(top_den_q)) > (PW'(top_num_q) * PW'(tden));
    best_lt = (PW'(top_num_q) * PW'(best_den_q)) < (PW'(best_num_q) * PW'(top_den_q));
  end

  // divider operands and one restoring step
  always_comb begin
    dvd_sel = ga_q;
    dsr_sel = gb_q;
    unique case (cmd_i.dsrc)
      DS_GCD:  begin dvd_sel = ga_q;               dsr_sel = gb_q;         end
      DS_NUM:  begin dvd_sel = best_num_q;         dsr_sel = DEN_W'(ga_q); end
      DS_DEN:  begin dvd_sel = DIST_W'(best_den_q); dsr_sel = DEN_W'(ga_q); end
      default: begin dvd_sel = ga_q;               dsr_sel = gb_q;         end
    endcase
    rem_sh = {div_rem_q, div_dvd_q[DIST_W-1]};
    div_ge = rem_sh >= {1'b0, div_dsr_q};
    rem_nx = div_ge ? (rem_sh - {1'b0, div_dsr_q}) : rem_sh;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= ID_W'(1);
      total_q    <= '0;
      found_q    <= 1'b0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (cmd_i.total_clr) total_q <= '0;
      else if (e_we) total_q <= total_q + ET_W'(1);
      if (cmd_i.best_rst) found_q <= 1'b0;
      else if (cmd_i.best_upd && (!found_q || best_lt)) found_q <= 1'b1;
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= CW'(DIST_W);
      end else if (div_busy_q) begin
        div_cnt_q  <= div_cnt_q - CW'(1);
        div_busy_q <= (div_cnt_q != CW'(1));
      end
    end
  end

  // counters and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.v_rst) v_q <= VW'(1);
    else if (cmd_i.v_inc) v_q <= v_q + VW'(1);
    if (cmd_i.k_rst) k_q <= KW'(1);
    else if (cmd_i.k_inc) k_q <= k_q + KW'(1);
    if (cmd_i.i_rst) i_q <= '0;
    else if (cmd_i.i_inc) i_q <= i_q + ET_W'(1);

    if (cmd_i.e_latch) begin
      to_q <= VW'(r_to);
      w_q  <= r_w;
    end
    if (cmd_i.c_latch) begin
      src_ok_q <= d_ok;
      cand_q   <= d_val + DIST_W'(w_q);
    end
    if (cmd_i.t_latch) dn1_q <= d_val;

    if (cmd_i.top_rst) begin
      top_num_q <= '0;
      top_den_q <= DEN_W'(1);
    end else if (cmd_i.top_upd && term_ok && term_gt) begin
      top_num_q <= tnum;
      top_den_q <= tden;
    end

    if (cmd_i.best_rst) begin
      best_num_q <= '0;
      best_den_q <= DEN_W'(1);
    end else if (cmd_i.best_upd && (!found_q || best_lt)) begin
      best_num_q <= top_num_q;
      best_den_q <= top_den_q;
    end

    if (cmd_i.g_load) begin
      ga_q <= best_num_q;
      gb_q <= best_den_q;
    end else if (cmd_i.g_step) begin
      ga_q <= DIST_W'(gb_q);
      gb_q <= div_rem_q;
    end

    if (cmd_i.div_start) begin
      div_dvd_q <= dvd_sel;
      div_dsr_q <= dsr_sel;
      div_rem_q <= '0;
    end else if (div_busy_q) begin
      div_dvd_q <= {div_dvd_q[DIST_W-2:0], div_ge};
      div_rem_q <= DEN_W'(rem_nx);
    end

    if (cmd_i.num_latch) qnum_q <= div_dvd_q;
    if (cmd_i.den_latch) qden_q <= DEN_W'(div_dvd_q);
  end

  always_comb begin
    sts_o.edge_ok  = (int'(r_from) <= int'(n_w)) && (int'(r_to) <= int'(n_w));
    sts_o.d_ok     = d_ok;
    sts_o.v_last   = (v_q == n_w);
    sts_o.k_last   = (k_q == KW'(n_w));
    sts_o.i_end    = (i_q == total_q);
    sts_o.n_zero   = (n_w == '0);
    sts_o.found    = found_q;
    sts_o.div_done = !div_busy_q;
    sts_o.rem_zero = (div_rem_q == '0);
  end

  assign has_cycle_o        = found_q;
  assign mean_numerator_o   = found_q ? NUM_W'(qnum_q) : '0;
  assign mean_denominator_o = found_q ? DEN_OUT_W'(qden_q) : DEN_OUT_W'(1);
endmodule
`default_nettype wire
